### hw/rtl/wino_pkg.sv
// ----------------------------------------------------------------------------
// wino_pkg
// Shared types and constants of the Winograd F(2x2,3x3) tile accumulator.
// ----------------------------------------------------------------------------
package wino_pkg;

    // Default sample/weight width and accumulator width
    localparam int DATA_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF  = 48;

    // Fixed result and bias width
    localparam int OUT_W = 32;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Last tile row, on which the transforms fire, and first tile row
    localparam logic [1:0] LAST_ROW  = 2'd3;
    localparam logic [1:0] FIRST_ROW = 2'd0;

    // Configuration register indexes
    localparam logic [1:0] CFG_POST_OP      = 2'd0;
    localparam logic [1:0] CFG_RELU_CAP     = 2'd1;
    localparam logic [1:0] CFG_RESULT_SHIFT = 2'd2;

    // Post-op codes; the unused code acts as none
    localparam logic [1:0] POST_NONE = 2'd0;
    localparam logic [1:0] POST_RELU = 2'd1;
    localparam logic [1:0] POST_CAP  = 2'd2;

    // Configuration reset values
    localparam logic [1:0]  POST_OP_RST      = POST_NONE;
    localparam logic [30:0] RELU_CAP_RST     = 31'd6;
    localparam logic [4:0]  RESULT_SHIFT_RST = 5'd0;

    // Per-tile control carried with each transformed tile
    typedef struct packed {
        logic clear;   // zero the accumulator before adding this tile
        logic emit;    // produce a 2x2 result after adding this tile
    } ctl_t;

endpackage

### hw/rtl/wino_front.sv
// ----------------------------------------------------------------------------
// wino_front
// Accepts tile rows, holds rows 0 to 2, and on row 3 forms the input
// transform B^T d B and the scaled filter transform 4 G g G^T.
// ----------------------------------------------------------------------------
module wino_front
    import wino_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [DATA_WIDTH-1:0]          sample_a,
    input  logic signed [DATA_WIDTH-1:0]          sample_b,
    input  logic signed [DATA_WIDTH-1:0]          sample_c,
    input  logic signed [DATA_WIDTH-1:0]          sample_d,
    input  logic signed [DATA_WIDTH-1:0]          weight_a,
    input  logic signed [DATA_WIDTH-1:0]          weight_b,
    input  logic signed [DATA_WIDTH-1:0]          weight_c,
    input  logic signed [OUT_W-1:0]               bias,
    input  logic                                  start_sum,
    input  logic                                  end_sum,
    input  logic                                  q_full,
    output logic                                  push,
    output logic [15:0][DATA_WIDTH+1:0]           push_u,
    output logic [15:0][DATA_WIDTH+3:0]           push_w,
    output logic [OUT_W-1:0]                      push_bias,
    output ctl_t                                  push_ctl
);

    localparam int BW = DATA_WIDTH + 1;   // first input transform pass
    localparam int UW = DATA_WIDTH + 2;   // transformed input
    localparam int GW = DATA_WIDTH + 2;   // first filter transform pass
    localparam int WW = DATA_WIDTH + 4;   // transformed filter

    logic [1:0]                   row_reg;
    logic                         clear_pend_reg;
    logic signed [DATA_WIDTH-1:0] tile_reg [12];
    logic signed [DATA_WIDTH-1:0] wt_reg [9];

    logic                         accept;
    logic signed [DATA_WIDTH-1:0] d [16];
    logic signed [BW-1:0]         bd [16];
    logic signed [UW-1:0]         u [16];
    logic signed [GW-1:0]         gg [12];
    logic signed [WW-1:0]         w [16];

    // Hold row 3 while the queue has no room
    assign in_stall = (row_reg == LAST_ROW) && q_full;
    assign accept   = in_valid && !in_stall;

    // Advance the row counter and capture the clear request of row 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= FIRST_ROW;
            clear_pend_reg <= 1'b0;
        end
        else if (accept)
        begin
            row_reg <= row_reg + 2'd1;
            if (row_reg == FIRST_ROW)
            begin
                clear_pend_reg <= start_sum;
            end
        end
    end

    // Hold tile rows 0 to 2 and filter rows 0 to 2
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (row_reg == 2'(r))
                begin
                    tile_reg[r*4+0] <= sample_a;
                    tile_reg[r*4+1] <= sample_b;
                    tile_reg[r*4+2] <= sample_c;
                    tile_reg[r*4+3] <= sample_d;
                    wt_reg[r*3+0]   <= weight_a;
                    wt_reg[r*3+1]   <= weight_b;
                    wt_reg[r*3+2]   <= weight_c;
                end
            end
        end
    end

    // Input tile: stored rows plus the current row
    always_comb
    begin
        for (int i = 0; i < 12; i++)
        begin
            d[i] = tile_reg[i];
        end
        d[12] = sample_a;
        d[13] = sample_b;
        d[14] = sample_c;
        d[15] = sample_d;
    end

    // Input transform B^T d B, columns first then rows
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            bd[i]    = BW'(d[i])   - BW'(d[8+i]);
            bd[4+i]  = BW'(d[4+i]) + BW'(d[8+i]);
            bd[8+i]  = BW'(d[8+i]) - BW'(d[4+i]);
            bd[12+i] = BW'(d[4+i]) - BW'(d[12+i]);
        end
        for (int i = 0; i < 4; i++)
        begin
            u[i*4+0] = UW'(bd[i*4+0]) - UW'(bd[i*4+2]);
            u[i*4+1] = UW'(bd[i*4+1]) + UW'(bd[i*4+2]);
            u[i*4+2] = UW'(bd[i*4+2]) - UW'(bd[i*4+1]);
            u[i*4+3] = UW'(bd[i*4+1]) - UW'(bd[i*4+3]);
        end
    end

    // Filter transform 4 G g G^T, exact in integers
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            gg[i]   = GW'(wt_reg[i]) + GW'(wt_reg[i]);
            gg[3+i] = GW'(wt_reg[i]) + GW'(wt_reg[3+i]) + GW'(wt_reg[6+i]);
            gg[6+i] = GW'(wt_reg[i]) - GW'(wt_reg[3+i]) + GW'(wt_reg[6+i]);
            gg[9+i] = GW'(wt_reg[6+i]) + GW'(wt_reg[6+i]);
        end
        for (int i = 0; i < 4; i++)
        begin
            w[i*4+0] = WW'(gg[i*3]) + WW'(gg[i*3]);
            w[i*4+1] = WW'(gg[i*3]) + WW'(gg[i*3+1]) + WW'(gg[i*3+2]);
            w[i*4+2] = WW'(gg[i*3]) - WW'(gg[i*3+1]) + WW'(gg[i*3+2]);
            w[i*4+3] = WW'(gg[i*3+2]) + WW'(gg[i*3+2]);
        end
    end

    // Push one transformed tile per accepted row 3
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            push_u[i] = u[i];
            push_w[i] = w[i];
        end
    end

    assign push           = accept && (row_reg == LAST_ROW);
    assign push_bias      = bias;
    assign push_ctl.clear = clear_pend_reg;
    assign push_ctl.emit  = end_sum;

endmodule

### hw/rtl/wino_queue.sv
// ----------------------------------------------------------------------------
// wino_queue
// Short first-in first-out queue of transformed tiles between the front
// and the multiply-accumulate back end.
// ----------------------------------------------------------------------------
module wino_queue
    import wino_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/wino_mac.sv
// ----------------------------------------------------------------------------
// wino_mac
// Multiplies the two transformed 4x4 arrays element by element and adds
// each of the 16 products into its own wrapping accumulator.
// ----------------------------------------------------------------------------
module wino_mac
    import wino_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          load,
    input  logic [15:0][DATA_WIDTH+1:0]   tile_u,
    input  logic [15:0][DATA_WIDTH+3:0]   tile_w,
    input  logic [OUT_W-1:0]              tile_bias,
    input  ctl_t                          tile_ctl,
    output logic [15:0][ACC_WIDTH-1:0]    acc,
    output logic                          emit,
    output logic [OUT_W-1:0]              emit_bias
);

    localparam int UW = DATA_WIDTH + 2;
    localparam int WW = DATA_WIDTH + 4;
    localparam int PW = UW + WW;

    logic signed [PW-1:0]  prod_reg [16];
    logic signed [PW-1:0]  prod_next [16];
    logic                  v1_reg;
    ctl_t                  ctl1_reg;
    logic [OUT_W-1:0]      bias1_reg;
    logic [ACC_WIDTH-1:0]  acc_reg [16];
    logic                  emit_reg;
    logic [OUT_W-1:0]      bias2_reg;

    // Element-wise products
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            prod_next[i] = PW'($signed(tile_u[i])) * PW'($signed(tile_w[i]));
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            emit_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg   <= load;
            emit_reg <= v1_reg && ctl1_reg.emit;
        end
    end

    // Register products and tile control
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 16; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            ctl1_reg  <= tile_ctl;
            bias1_reg <= tile_bias;
            bias2_reg <= bias1_reg;
        end
    end

    // Accumulate, clearing first when the tile asks for it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (adv && v1_reg)
        begin
            for (int i = 0; i < 16; i++)
            begin
                acc_reg[i] <= (ctl1_reg.clear ? '0 : acc_reg[i]) + ACC_WIDTH'(prod_reg[i]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            acc[i] = acc_reg[i];
        end
    end

    assign emit      = emit_reg;
    assign emit_bias = bias2_reg;

endmodule

### hw/rtl/wino_post.sv
// ----------------------------------------------------------------------------
// wino_post
// Output transform A^T M A with 64-bit saturation, scaling shift, 32-bit
// saturation, bias, post-op and the output register.
// ----------------------------------------------------------------------------
module wino_post
    import wino_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        emit,
    input  logic [OUT_W-1:0]            emit_bias,
    input  logic [15:0][ACC_WIDTH-1:0]  acc,
    input  logic [1:0]                  post_op,
    input  logic [30:0]                 relu_cap,
    input  logic [4:0]                  result_shift,
    output logic                        adv,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [OUT_W-1:0]     out_top_left,
    output logic signed [OUT_W-1:0]     out_top_right,
    output logic signed [OUT_W-1:0]     out_bottom_left,
    output logic signed [OUT_W-1:0]     out_bottom_right,
    output logic                        clipped
);

    localparam int SW = 64;

    typedef struct packed {
        logic          clip;
        logic [SW-1:0] value;
    } sat64_t;

    typedef struct packed {
        logic             clip;
        logic [OUT_W-1:0] value;
    } sat32_t;

    function automatic sat64_t sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0] s;
        sat64_t      r;
        s = {a[SW-1], a} + {b[SW-1], b};
        r.clip  = (s[SW] != s[SW-1]);
        r.value = r.clip ? {s[SW], {(SW-1){~s[SW]}}} : s[SW-1:0];
        return r;
    endfunction

    function automatic sat64_t sat_sub(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0] s;
        sat64_t      r;
        s = {a[SW-1], a} - {b[SW-1], b};
        r.clip  = (s[SW] != s[SW-1]);
        r.value = r.clip ? {s[SW], {(SW-1){~s[SW]}}} : s[SW-1:0];
        return r;
    endfunction

    function automatic sat32_t sat_narrow(input logic [SW-1:0] v);
        sat32_t r;
        r.clip  = !((&v[SW-1:OUT_W-1]) || (~|v[SW-1:OUT_W-1]));
        r.value = r.clip ? {v[SW-1], {(OUT_W-1){~v[SW-1]}}} : v[OUT_W-1:0];
        return r;
    endfunction

    // Stage registers
    logic             v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic [SW-1:0]    x_reg [4];
    logic [SW-1:0]    y_reg [4];
    logic [SW-1:0]    m8_reg [4];
    logic [SW-1:0]    m12_reg [4];
    logic [SW-1:0]    t0_reg [4];
    logic [SW-1:0]    t1_reg [4];
    logic [SW-1:0]    a_reg [4];
    logic [SW-1:0]    c_reg [4];
    logic [SW-1:0]    o_reg [4];
    logic [OUT_W-1:0] n_reg [4];
    logic             clip3_reg, clip4_reg, clip5_reg, clip6_reg, clip7_reg;
    logic [OUT_W-1:0] bias3_reg, bias4_reg, bias5_reg, bias6_reg, bias7_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] res_reg [4];
    logic             clip_out_reg;

    // Stage results
    logic [SW-1:0]    m [16];
    sat64_t           x_s [4];
    sat64_t           y_s [4];
    sat64_t           t0_s [4];
    sat64_t           t1_s [4];
    sat64_t           a_s [4];
    sat64_t           o_s [4];
    sat32_t           n_s [4];
    logic [OUT_W-1:0] res_next [4];
    logic             clip3_next, clip4_next, clip5_next, clip6_next, clip7_next;
    logic             clip_out_next;
    logic [5:0]       shift_amt;

    // Freeze the whole back end while a result waits
    assign adv = !(out_valid_reg && out_stall);

    // Column pass, first add
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            m[i] = SW'($signed(acc[i]));
        end
        clip3_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            x_s[i] = sat_add(m[i], m[4+i]);
            y_s[i] = sat_sub(m[4+i], m[8+i]);
            clip3_next = clip3_next | x_s[i].clip | y_s[i].clip;
        end
    end

    // Column pass, second add
    always_comb
    begin
        clip4_next = clip3_reg;
        for (int i = 0; i < 4; i++)
        begin
            t0_s[i] = sat_add(x_reg[i], m8_reg[i]);
            t1_s[i] = sat_sub(y_reg[i], m12_reg[i]);
            clip4_next = clip4_next | t0_s[i].clip | t1_s[i].clip;
        end
    end

    // Row pass, first add
    always_comb
    begin
        a_s[0] = sat_add(t0_reg[0], t0_reg[1]);
        a_s[1] = sat_sub(t0_reg[1], t0_reg[2]);
        a_s[2] = sat_add(t1_reg[0], t1_reg[1]);
        a_s[3] = sat_sub(t1_reg[1], t1_reg[2]);
        clip5_next = clip4_reg | a_s[0].clip | a_s[1].clip | a_s[2].clip | a_s[3].clip;
    end

    // Row pass, second add
    always_comb
    begin
        o_s[0] = sat_add(a_reg[0], c_reg[0]);
        o_s[1] = sat_sub(a_reg[1], c_reg[1]);
        o_s[2] = sat_add(a_reg[2], c_reg[2]);
        o_s[3] = sat_sub(a_reg[3], c_reg[3]);
        clip6_next = clip5_reg | o_s[0].clip | o_s[1].clip | o_s[2].clip | o_s[3].clip;
    end

    // Drop the filter scale and extra shift, then narrow to 32 bits
    always_comb
    begin
        shift_amt  = 6'd2 + 6'(result_shift);
        clip7_next = clip6_reg;
        for (int i = 0; i < 4; i++)
        begin
            n_s[i] = sat_narrow(SW'($signed(o_reg[i]) >>> shift_amt));
            clip7_next = clip7_next | n_s[i].clip;
        end
    end

    // Bias with saturation, then post-op
    always_comb
    begin
        logic [OUT_W:0]         s;
        logic                   ovf;
        logic signed [OUT_W-1:0] r;
        clip_out_next = clip7_reg;
        for (int i = 0; i < 4; i++)
        begin
            s   = {n_reg[i][OUT_W-1], n_reg[i]} + {bias7_reg[OUT_W-1], bias7_reg};
            ovf = (s[OUT_W] != s[OUT_W-1]);
            r   = ovf ? {s[OUT_W], {(OUT_W-1){~s[OUT_W]}}} : s[OUT_W-1:0];
            clip_out_next = clip_out_next | ovf;
            if (post_op inside {POST_RELU, POST_CAP})
            begin
                if (r < 0)
                begin
                    r = '0;
                end
                if ((post_op == POST_CAP) && (r > $signed({1'b0, relu_cap})))
                begin
                    r = $signed({1'b0, relu_cap});
                end
            end
            res_next[i] = r;
        end
    end

    // Stage valid flags and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg        <= emit;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            out_valid_reg <= v7_reg;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                x_reg[i]   <= x_s[i].value;
                y_reg[i]   <= y_s[i].value;
                m8_reg[i]  <= m[8+i];
                m12_reg[i] <= m[12+i];
                t0_reg[i]  <= t0_s[i].value;
                t1_reg[i]  <= t1_s[i].value;
                a_reg[i]   <= a_s[i].value;
                o_reg[i]   <= o_s[i].value;
                n_reg[i]   <= n_s[i].value;
            end
            c_reg[0]  <= t0_reg[2];
            c_reg[1]  <= t0_reg[3];
            c_reg[2]  <= t1_reg[2];
            c_reg[3]  <= t1_reg[3];
            clip3_reg <= clip3_next;
            clip4_reg <= clip4_next;
            clip5_reg <= clip5_next;
            clip6_reg <= clip6_next;
            clip7_reg <= clip7_next;
            bias3_reg <= emit_bias;
            bias4_reg <= bias3_reg;
            bias5_reg <= bias4_reg;
            bias6_reg <= bias5_reg;
            bias7_reg <= bias6_reg;
            if (v7_reg)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    res_reg[i] <= res_next[i];
                end
                clip_out_reg <= clip_out_next;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_top_left     = res_reg[0];
    assign out_top_right    = res_reg[1];
    assign out_bottom_left  = res_reg[2];
    assign out_bottom_right = res_reg[3];
    assign clipped          = clip_out_reg;

endmodule

### hw/rtl/winograd_f2x2_3x3_tile_accumulator.sv
// ----------------------------------------------------------------------------
// winograd_f2x2_3x3_tile_accumulator
// Throughput: one tile row per cycle while in_stall is low; a tile takes four rows.
// A result reaches the output register from its accepted row 3 through the queue,
// multiply and accumulate registers and six post stages; out_stall can hold it.
// Reset clears row count, accumulator and queue and loads the configuration reset values.
// ----------------------------------------------------------------------------
module winograd_f2x2_3x3_tile_accumulator
    import wino_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [30:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [DATA_WIDTH-1:0]  sample_a,
    input  logic signed [DATA_WIDTH-1:0]  sample_b,
    input  logic signed [DATA_WIDTH-1:0]  sample_c,
    input  logic signed [DATA_WIDTH-1:0]  sample_d,
    input  logic signed [DATA_WIDTH-1:0]  weight_a,
    input  logic signed [DATA_WIDTH-1:0]  weight_b,
    input  logic signed [DATA_WIDTH-1:0]  weight_c,
    input  logic signed [OUT_W-1:0]       bias,
    input  logic                          start_sum,
    input  logic                          end_sum,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [OUT_W-1:0]       out_top_left,
    output logic signed [OUT_W-1:0]       out_top_right,
    output logic signed [OUT_W-1:0]       out_bottom_left,
    output logic signed [OUT_W-1:0]       out_bottom_right,
    output logic                          clipped
);

    localparam int UW      = DATA_WIDTH + 2;
    localparam int WW      = DATA_WIDTH + 4;
    localparam int U_BITS  = 16 * UW;
    localparam int W_BITS  = 16 * WW;
    localparam int ENTRY_W = $bits(ctl_t) + OUT_W + W_BITS + U_BITS;

    logic [1:0]              post_op_reg;
    logic [30:0]             relu_cap_reg;
    logic [4:0]              result_shift_reg;

    logic                    push;
    logic [15:0][UW-1:0]     push_u;
    logic [15:0][WW-1:0]     push_w;
    logic [OUT_W-1:0]        push_bias;
    ctl_t                    push_ctl;
    logic                    q_full;
    logic                    q_valid;
    logic                    pop;
    logic [ENTRY_W-1:0]      q_in;
    logic [ENTRY_W-1:0]      q_out;
    logic [15:0][UW-1:0]     tile_u;
    logic [15:0][WW-1:0]     tile_w;
    logic [OUT_W-1:0]        tile_bias;
    ctl_t                    tile_ctl;
    logic                    adv;
    logic [15:0][ACC_WIDTH-1:0] acc;
    logic                    emit;
    logic [OUT_W-1:0]        emit_bias;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_op_reg      <= POST_OP_RST;
            relu_cap_reg     <= RELU_CAP_RST;
            result_shift_reg <= RESULT_SHIFT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_POST_OP:      post_op_reg      <= cfg_data[1:0];
                CFG_RELU_CAP:     relu_cap_reg     <= cfg_data;
                CFG_RESULT_SHIFT: result_shift_reg <= cfg_data[4:0];
                default:          ;
            endcase
        end
    end

    // Front: row capture and transforms
    wino_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample_a  (sample_a),
        .sample_b  (sample_b),
        .sample_c  (sample_c),
        .sample_d  (sample_d),
        .weight_a  (weight_a),
        .weight_b  (weight_b),
        .weight_c  (weight_c),
        .bias      (bias),
        .start_sum (start_sum),
        .end_sum   (end_sum),
        .q_full    (q_full),
        .push      (push),
        .push_u    (push_u),
        .push_w    (push_w),
        .push_bias (push_bias),
        .push_ctl  (push_ctl)
    );

    // Pack and unpack queue beats
    assign q_in      = {push_ctl, push_bias, push_w, push_u};
    assign tile_u    = q_out[U_BITS-1:0];
    assign tile_w    = q_out[U_BITS +: W_BITS];
    assign tile_bias = q_out[U_BITS+W_BITS +: OUT_W];
    assign tile_ctl  = ctl_t'(q_out[ENTRY_W-1 -: $bits(ctl_t)]);
    assign pop       = adv && q_valid;

    wino_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_data  (q_out)
    );

    // Back: multiply-accumulate
    wino_mac #(
        .DATA_WIDTH (DATA_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .load      (pop),
        .tile_u    (tile_u),
        .tile_w    (tile_w),
        .tile_bias (tile_bias),
        .tile_ctl  (tile_ctl),
        .acc       (acc),
        .emit      (emit),
        .emit_bias (emit_bias)
    );

    // Back: output transform and result register
    wino_post #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_post (
        .clk              (clk),
        .rst_n            (rst_n),
        .emit             (emit),
        .emit_bias        (emit_bias),
        .acc              (acc),
        .post_op          (post_op_reg),
        .relu_cap         (relu_cap_reg),
        .result_shift     (result_shift_reg),
        .adv              (adv),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_top_left     (out_top_left),
        .out_top_right    (out_top_right),
        .out_bottom_left  (out_bottom_left),
        .out_bottom_right (out_bottom_right),
        .clipped          (clipped)
    );

endmodule
